FILE: hdl/ordered_list_append_remove_core_assert.svh
// Assertion macros shared by the ordered list core.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef ORDERED_LIST_APPEND_REMOVE_CORE_ASSERT_SVH
`define ORDERED_LIST_APPEND_REMOVE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define OLAR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olar: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define OLAR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olar: next-cycle check failed");

`endif

FILE: hdl/olar_pkg.sv
// Package for the ordered list core: sizes, operation and status codes,
// transfer structs and the microcode table. No dependencies.
package olar_pkg;

  localparam int CAPACITY    = 32;
  localparam int NUMBER_BITS = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Operation codes.
  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_DISPLAY = 2'd1;
  localparam logic [1:0] MODE_REMOVE  = 2'd2;
  localparam logic [1:0] MODE_IGNORE  = 2'd3;

  // Result status codes.
  localparam logic [2:0] STAT_APPENDED = 3'd0;
  localparam logic [2:0] STAT_REMOVED  = 3'd1;
  localparam logic [2:0] STAT_NOTFOUND = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;
  localparam logic [2:0] STAT_LISTED   = 3'd5;

  typedef struct packed {
    logic [1:0]             mode;
    logic [NUMBER_BITS-1:0] item_number;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [NUMBER_BITS-1:0] entry_value;
    logic                   last;
  } out_item_t;

  // Microprogram addresses.
  typedef logic [3:0] step_t;
  localparam step_t U_IDLE    = 4'd0;
  localparam step_t U_A_CHK   = 4'd1;
  localparam step_t U_A_WR    = 4'd2;
  localparam step_t U_A_FULL  = 4'd3;
  localparam step_t U_D_CHK   = 4'd4;
  localparam step_t U_D_OUT   = 4'd5;
  localparam step_t U_D_EMPTY = 4'd6;
  localparam step_t U_R_CHK   = 4'd7;
  localparam step_t U_R_CMP   = 4'd8;
  localparam step_t U_R_NXT   = 4'd9;
  localparam step_t U_R_SH    = 4'd10;
  localparam step_t U_R_EMPTY = 4'd11;
  localparam step_t U_R_NF    = 4'd12;
  localparam step_t U_R_MV    = 4'd13;
  localparam step_t U_R_DONE  = 4'd14;

  typedef enum logic [2:0] {
    COND_ALWAYS, COND_FULL, COND_EMPTY, COND_IDX_END, COND_MATCH
  } cond_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
  typedef enum logic       {WA_COUNT, WA_IDX_M1} waddr_sel_t;
  typedef enum logic       {WD_NUM, WD_RD} wdata_sel_t;
  typedef enum logic [1:0] {VAL_NUM, VAL_RD, VAL_ZERO} val_sel_t;
  typedef enum logic       {LAST_ONE, LAST_IDX_END} last_sel_t;

  typedef struct packed {
    cond_t      cond;
    step_t      tgt_t;
    step_t      tgt_f;
    logic       rd_en;
    logic       wr_en;
    waddr_sel_t waddr_sel;
    wdata_sel_t wdata_sel;
    logic       idx_inc;
    cnt_op_t    cnt_op;
    logic       emit;
    logic [2:0] status;
    val_sel_t   val_sel;
    last_sel_t  last_sel;
  } uword_t;

  localparam uword_t UW_NOP = '{
    cond: COND_ALWAYS, tgt_t: U_IDLE, tgt_f: U_IDLE, rd_en: 1'b0, wr_en: 1'b0,
    waddr_sel: WA_COUNT, wdata_sel: WD_NUM, idx_inc: 1'b0, cnt_op: CNT_HOLD,
    emit: 1'b0, status: STAT_APPENDED, val_sel: VAL_NUM, last_sel: LAST_ONE
  };

  // Control store: one word per step; a true condition jumps to tgt_t.
  function automatic uword_t olar_ucode(input step_t step);
    uword_t w;
    w = UW_NOP;
    case (step)
      U_A_CHK: begin
        w.cond = COND_FULL; w.tgt_t = U_A_FULL; w.tgt_f = U_A_WR;
      end
      U_A_WR: begin
        w.wr_en = 1'b1; w.waddr_sel = WA_COUNT; w.wdata_sel = WD_NUM;
        w.cnt_op = CNT_INC; w.emit = 1'b1; w.status = STAT_APPENDED;
      end
      U_A_FULL: begin
        w.emit = 1'b1; w.status = STAT_FULL;
      end
      U_D_CHK: begin
        w.rd_en = 1'b1; w.idx_inc = 1'b1;
        w.cond = COND_EMPTY; w.tgt_t = U_D_EMPTY; w.tgt_f = U_D_OUT;
      end
      U_D_OUT: begin
        w.rd_en = 1'b1; w.idx_inc = 1'b1; w.emit = 1'b1; w.status = STAT_LISTED;
        w.val_sel = VAL_RD; w.last_sel = LAST_IDX_END;
        w.cond = COND_IDX_END; w.tgt_t = U_IDLE; w.tgt_f = U_D_OUT;
      end
      U_D_EMPTY: begin
        w.emit = 1'b1; w.status = STAT_EMPTY; w.val_sel = VAL_ZERO;
      end
      U_R_CHK: begin
        w.rd_en = 1'b1; w.idx_inc = 1'b1;
        w.cond = COND_EMPTY; w.tgt_t = U_R_EMPTY; w.tgt_f = U_R_CMP;
      end
      U_R_CMP: begin
        w.cond = COND_MATCH; w.tgt_t = U_R_SH; w.tgt_f = U_R_NXT;
      end
      U_R_NXT: begin
        w.rd_en = 1'b1; w.idx_inc = 1'b1;
        w.cond = COND_IDX_END; w.tgt_t = U_R_NF; w.tgt_f = U_R_CMP;
      end
      U_R_SH: begin
        w.rd_en = 1'b1;
        w.cond = COND_IDX_END; w.tgt_t = U_R_DONE; w.tgt_f = U_R_MV;
      end
      U_R_EMPTY: begin
        w.emit = 1'b1; w.status = STAT_EMPTY;
      end
      U_R_NF: begin
        w.emit = 1'b1; w.status = STAT_NOTFOUND;
      end
      U_R_MV: begin
        w.wr_en = 1'b1; w.waddr_sel = WA_IDX_M1; w.wdata_sel = WD_RD;
        w.idx_inc = 1'b1; w.tgt_t = U_R_SH;
      end
      U_R_DONE: begin
        w.cnt_op = CNT_DEC; w.emit = 1'b1; w.status = STAT_REMOVED;
      end
      default: begin
        w = UW_NOP;
      end
    endcase
    return w;
  endfunction

  // Entry point of the microprogram for each operation.
  function automatic step_t olar_entry(input logic [1:0] mode);
    step_t s;
    case (mode)
      MODE_APPEND:  s = U_A_CHK;
      MODE_DISPLAY: s = U_D_CHK;
      MODE_REMOVE:  s = U_R_CHK;
      default:      s = U_IDLE;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/ordered_list_append_remove_core.sv
// Top level of the ordered list core: microcoded sequencer and datapath.
// Depends on olar_pkg, olar_store and ordered_list_append_remove_core_assert.svh.
//
// Usage. An operation is accepted at a rising edge where start is high and
// busy is low; in_item carries the mode and the number. Results leave on
// out_item, each for exactly one cycle with out_strobe high, and each is
// taken by the receiver at the edge that ends that cycle: the receiver
// cannot stall, so no result is ever held back. The final result of an
// operation has last set. A mode of three is dropped without any result.
// Append and the empty or full answers pass a check step and then an
// answer step, whose result is registered. Display reads the first entry
// in its check step and then gives one entry every cycle. Remove compares
// each stored entry in a compare step and a read step, and then closes the
// gap through a shift step and a move step per later entry. The sequencer
// walks the single read port of the entry store one address at a time. busy
// stays high until the final result has been registered, so the next
// operation may be accepted in the cycle in which that result is shown.
// Reset clears the entry count and the sequencer; the stored words keep
// whatever they held and only entries below the count are used.
module ordered_list_append_remove_core
  import olar_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  // Sequencer and datapath registers.
  step_t                  upc_r, upc_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [NUMBER_BITS-1:0] num_r, num_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  out_item_t              out_item_r, out_item_nxt;

  uword_t                 uw;
  logic                   accept;
  logic                   cond_true;
  logic                   match;
  logic                   idx_end;
  logic [CNT_W-1:0]       idx_m1;
  logic [IDX_W-1:0]       wr_addr;
  logic [NUMBER_BITS-1:0] wr_data;
  logic [NUMBER_BITS-1:0] rd_data;

  assign busy   = (upc_r != U_IDLE);
  assign accept = start && !busy;

  // The control word of the current step; the idle step is a no-op word.
  assign uw = olar_ucode(upc_r);

  assign match   = (rd_data == num_r);
  assign idx_end = (idx_r == count_r);
  assign idx_m1  = idx_r - CNT_W'(1);

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:  cond_true = 1'b1;
      COND_FULL:    cond_true = (count_r == CNT_W'(CAPACITY));
      COND_EMPTY:   cond_true = (count_r == '0);
      COND_IDX_END: cond_true = idx_end;
      COND_MATCH:   cond_true = match;
      default:      cond_true = 1'b1;
    endcase
  end

  // Next step: dispatch on the operation when idle, otherwise follow the
  // two-way branch held in the control word.
  always_comb begin
    if (busy) begin
      upc_nxt = cond_true ? uw.tgt_t : uw.tgt_f;
    end else if (accept) begin
      upc_nxt = olar_entry(in_item.mode);
    end else begin
      upc_nxt = U_IDLE;
    end
  end

  always_comb begin
    if (accept) begin
      idx_nxt = '0;
      num_nxt = in_item.item_number;
    end else begin
      idx_nxt = uw.idx_inc ? idx_r + CNT_W'(1) : idx_r;
      num_nxt = num_r;
    end
  end

  always_comb begin
    case (uw.cnt_op)
      CNT_INC: count_nxt = count_r + CNT_W'(1);
      CNT_DEC: count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // Writes land either at the tail (append) or one slot below the walking
  // index (closing the gap after a removal).
  assign wr_addr = (uw.waddr_sel == WA_COUNT) ? count_r[IDX_W-1:0] : idx_m1[IDX_W-1:0];
  assign wr_data = (uw.wdata_sel == WD_NUM) ? num_r : rd_data;

  olar_store u_store (
    .clk     (clk),
    .rd_en   (uw.rd_en),
    .rd_addr (idx_r[IDX_W-1:0]),
    .wr_en   (uw.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Result register: filled by any step that emits.
  always_comb begin
    out_strobe_nxt      = uw.emit;
    out_item_nxt        = out_item_r;
    if (uw.emit) begin
      out_item_nxt.status = uw.status;
      case (uw.val_sel)
        VAL_NUM:  out_item_nxt.entry_value = num_r;
        VAL_RD:   out_item_nxt.entry_value = rd_data;
        default:  out_item_nxt.entry_value = '0;
      endcase
      out_item_nxt.last = (uw.last_sel == LAST_ONE) ? 1'b1 : idx_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= U_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      upc_r        <= upc_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    num_r      <= num_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`include "ordered_list_append_remove_core_assert.svh"

  // The count never passes the capacity.
  `OLAR_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  // A result marks last exactly when the sequencer has gone back to idle.
  `OLAR_ASSERT_IMP(a_last_idle, out_strobe, out_item.last == !busy)
  // Any real operation keeps the block busy in the following cycle.
  `OLAR_ASSERT_NXT(a_accept_busy, accept && (in_item.mode != MODE_IGNORE), busy)
  // The list size only moves while an operation is in progress.
  `OLAR_ASSERT_NXT(a_idle_count, !busy, $stable(count_r))

endmodule

FILE: hdl/olar_store.sv
// Entry store of the ordered list: one write port, one registered read port.
// Depends on olar_pkg for the depth and word width.
module olar_store
  import olar_pkg::*;
(
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [IDX_W-1:0]       rd_addr,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_addr,
  input  logic [NUMBER_BITS-1:0] wr_data,
  output logic [NUMBER_BITS-1:0] rd_data
);

  logic [NUMBER_BITS-1:0] mem [CAPACITY];
  logic [NUMBER_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: dv/ordered_list_append_remove_core_tb.sv
// Self-checking testbench for ordered_list_append_remove_core: a directed table of operations,
// then fill and drain phases of random operations, all checked against a queue-based model.
// Depends on olar_pkg and the core RTL only.
module ordered_list_append_remove_core_tb
  import olar_pkg::*;
();

  // Number of random operations after the directed table.
  localparam int RANDOM_OPS    = 364;
  // The slowest legal stretch without any transfer is a remove that walks the whole list
  // plus a sender gap, so this is many times the worst case.
  localparam int STALL_LIMIT   = 1000;
  // Quiet time after the last expected result, long enough for a stray late result to show.
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;

  typedef logic [NUMBER_BITS-1:0] number_t;

  // One row of the directed table. Where typed is set, the row carries its own expected
  // answer, which is always a single result with last set.
  typedef struct {
    logic [1:0]  mode;
    number_t     number;
    int unsigned repeats;
    bit          typed;
    logic [2:0]  status;
    number_t     value;
  } op_row_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  // Model state: the list contents in order, and the results still owed by the core.
  number_t   stored_q[$];
  out_item_t awaited_q[$];
  op_row_t   table_q[$];

  int unsigned failures      = 0;
  int unsigned results_seen  = 0;
  int unsigned mode_counts[4] = '{default: 0};
  int unsigned full_hits     = 0;
  int unsigned empty_hits    = 0;
  int unsigned burst_left    = 0;
  int unsigned quiet_cycles  = 0;

  always #5 clk = ~clk;

  ordered_list_append_remove_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  // Works out the results of one accepted operation and updates the model list. Remove takes
  // the first matching entry and closes the gap; display lists every entry in order.
  function automatic void predict_list_op(input in_item_t op, ref out_item_t res[$]);
    int pos;
    res.delete();
    pos = -1;
    case (op.mode)
      MODE_APPEND: begin
        if (stored_q.size() >= CAPACITY) begin
          full_hits++;
          res.push_back(out_item_t'{STAT_FULL, op.item_number, 1'b1});
        end else begin
          stored_q.push_back(op.item_number);
          res.push_back(out_item_t'{STAT_APPENDED, op.item_number, 1'b1});
        end
      end
      MODE_DISPLAY: begin
        if (stored_q.size() == 0) begin
          empty_hits++;
          res.push_back(out_item_t'{STAT_EMPTY, number_t'(0), 1'b1});
        end else begin
          foreach (stored_q[i])
            res.push_back(out_item_t'{STAT_LISTED, stored_q[i], i == stored_q.size() - 1});
        end
      end
      MODE_REMOVE: begin
        if (stored_q.size() == 0) begin
          empty_hits++;
          res.push_back(out_item_t'{STAT_EMPTY, op.item_number, 1'b1});
        end else begin
          for (int i = 0; i < stored_q.size(); i++) begin
            if (pos < 0 && stored_q[i] == op.item_number) pos = i;
          end
          if (pos < 0) begin
            res.push_back(out_item_t'{STAT_NOTFOUND, op.item_number, 1'b1});
          end else begin
            stored_q.delete(pos);
            res.push_back(out_item_t'{STAT_REMOVED, op.item_number, 1'b1});
          end
        end
      end
      default: begin
        // The unused mode is dropped by the core without any result.
      end
    endcase
  endfunction

  // Numbers lean towards a small pool so that duplicates are common, with the all-zero and
  // all-one values mixed in and full-range values for the rest.
  function automatic number_t random_number();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) return number_t'($urandom_range(15));
    if (pick < 40) return $urandom_range(1) ? '1 : '0;
    return number_t'($urandom());
  endfunction

  // In a fill phase most operations append; in a drain phase most remove, and removes mostly
  // name a number that is stored so that they reach deep into the list before matching.
  function automatic in_item_t random_op(input bit filling);
    in_item_t    op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < (filling ? 70 : 15))   op.mode = MODE_APPEND;
    else if (pick < 80)               op.mode = MODE_REMOVE;
    else if (pick < 95)               op.mode = MODE_DISPLAY;
    else                              op.mode = MODE_IGNORE;
    if (op.mode == MODE_REMOVE && stored_q.size() != 0 && $urandom_range(99) < 75)
      op.item_number = stored_q[$urandom_range(stored_q.size() - 1)];
    else
      op.item_number = random_number();
    return op;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      failures++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  // The sender works in bursts. Between bursts start is lowered for a random number of
  // cycles; some bursts are long, giving stretches where start never drops.
  task automatic sender_pause();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
  endtask

  // Presents one operation and holds it until the core takes the transfer, then records what
  // the core now owes. A typed row replaces the predicted answer with its own.
  task automatic transfer_op(input in_item_t op, input bit typed, input out_item_t typed_res);
    out_item_t res[$];
    start   <= 1'b1;
    in_item <= op;
    do begin
      @(posedge clk);
    end while (busy);
    predict_list_op(op, res);
    if (typed) res = '{typed_res};
    foreach (res[i]) awaited_q.push_back(res[i]);
    mode_counts[op.mode]++;
  endtask

  task automatic add_row(input logic [1:0] mode, input number_t number,
                         input int unsigned repeats, input bit typed,
                         input logic [2:0] status, input number_t value);
    table_q.push_back('{mode, number, repeats, typed, status, value});
  endtask

  // Every result transfer is compared with the oldest outstanding expectation. Sampling at
  // the clock edge sees the values that the core presented during the cycle just ended.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (awaited_q.size() == 0) begin
        failures++;
        $error("unexpected result: status %0d, entry_value %0h, last %0b",
               out_item.status, out_item.entry_value, out_item.last);
      end else begin
        want = awaited_q.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("entry_value", want.entry_value, out_item.entry_value);
        check_field("last", want.last, out_item.last);
      end
    end
  end

  // Watchdog: counts cycles in which neither an operation nor a result is transferred.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results still owed.",
               STALL_LIMIT, awaited_q.size());
      $display("ordered_list_append_remove_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_item_t    op;
    out_item_t   typed_res;
    bit          filling;
    bit          at_limit;
    int unsigned brink_ops;
    int unsigned brink_target;

    // Directed table. The first rows cover the empty list for both display and remove,
    // the extremes of the number, the unused mode and a remove that finds nothing.
    add_row(MODE_DISPLAY, 16'h0000, 1, 1'b1, STAT_EMPTY,    16'h0000);
    add_row(MODE_REMOVE,  16'h1234, 1, 1'b1, STAT_EMPTY,    16'h1234);
    add_row(MODE_APPEND,  16'h0000, 1, 1'b1, STAT_APPENDED, 16'h0000);
    add_row(MODE_APPEND,  16'hFFFF, 1, 1'b1, STAT_APPENDED, 16'hFFFF);
    add_row(MODE_IGNORE,  16'hABCD, 1, 1'b0, STAT_APPENDED, 16'h0000);
    add_row(MODE_APPEND,  16'h8001, 1, 1'b1, STAT_APPENDED, 16'h8001);
    add_row(MODE_DISPLAY, 16'h5A5A, 1, 1'b0, STAT_APPENDED, 16'h0000);
    add_row(MODE_REMOVE,  16'h5555, 1, 1'b1, STAT_NOTFOUND, 16'h5555);
    // Remove from the middle, then a duplicate so that first-match order matters.
    add_row(MODE_REMOVE,  16'hFFFF, 1, 1'b1, STAT_REMOVED,  16'hFFFF);
    add_row(MODE_APPEND,  16'h0000, 1, 1'b1, STAT_APPENDED, 16'h0000);
    add_row(MODE_DISPLAY, 16'h0000, 1, 1'b0, STAT_APPENDED, 16'h0000);
    add_row(MODE_REMOVE,  16'h0000, 1, 1'b1, STAT_REMOVED,  16'h0000);
    add_row(MODE_REMOVE,  16'h0000, 1, 1'b1, STAT_REMOVED,  16'h0000);
    add_row(MODE_DISPLAY, 16'hFFFF, 1, 1'b0, STAT_APPENDED, 16'h0000);
    add_row(MODE_REMOVE,  16'h8001, 1, 1'b1, STAT_REMOVED,  16'h8001);
    add_row(MODE_DISPLAY, 16'h0000, 1, 1'b1, STAT_EMPTY,    16'h0000);
    // Fill to capacity with one repeated number, then append into a full list, list all
    // entries, and remove at the head so that every later entry has to move down.
    add_row(MODE_APPEND,  16'h00A5, CAPACITY, 1'b1, STAT_APPENDED, 16'h00A5);
    add_row(MODE_APPEND,  16'h7E7E, 1, 1'b1, STAT_FULL,     16'h7E7E);
    add_row(MODE_DISPLAY, 16'h0000, 1, 1'b0, STAT_APPENDED, 16'h0000);
    add_row(MODE_IGNORE,  16'h0000, 1, 1'b0, STAT_APPENDED, 16'h0000);
    add_row(MODE_REMOVE,  16'h00A5, 1, 1'b1, STAT_REMOVED,  16'h00A5);
    add_row(MODE_APPEND,  16'hFFFF, 1, 1'b1, STAT_APPENDED, 16'hFFFF);
    add_row(MODE_DISPLAY, 16'h0000, 1, 1'b0, STAT_APPENDED, 16'h0000);
    add_row(MODE_REMOVE,  16'hFFFF, 1, 1'b1, STAT_REMOVED,  16'hFFFF);
    add_row(MODE_REMOVE,  16'h7E7E, 1, 1'b1, STAT_NOTFOUND, 16'h7E7E);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (table_q[r]) begin
      for (int k = 0; k < table_q[r].repeats; k++) begin
        op.mode        = table_q[r].mode;
        op.item_number = table_q[r].number;
        typed_res      = out_item_t'{table_q[r].status, table_q[r].value, 1'b1};
        sender_pause();
        transfer_op(op, table_q[r].typed, typed_res);
      end
    end

    // Random part: alternate between filling and draining the list. Each phase runs until
    // the list is full (or empty) and then a few operations beyond, so that appends into a
    // full list and removes from an empty one keep turning up.
    filling      = 1'b0;
    brink_ops    = 0;
    brink_target = $urandom_range(1, 3);
    for (int n = 0; n < RANDOM_OPS; n++) begin
      at_limit = filling ? (stored_q.size() == CAPACITY) : (stored_q.size() == 0);
      if (at_limit) begin
        brink_ops++;
        if (brink_ops > brink_target) begin
          filling      = !filling;
          brink_ops    = 0;
          brink_target = $urandom_range(1, 3);
        end
      end
      op = random_op(filling);
      sender_pause();
      transfer_op(op, 1'b0, out_item_t'('0));
    end
    start <= 1'b0;

    // Wait for every owed result, then leave room for any stray result to appear.
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d appends, %0d displays, %0d removes and %0d operations of the unused mode.",
             mode_counts[MODE_APPEND], mode_counts[MODE_DISPLAY], mode_counts[MODE_REMOVE],
             mode_counts[MODE_IGNORE]);
    $display("Checked %0d results; %0d appends met a full list, %0d empty answers came back.",
             results_seen, full_hits, empty_hits);
    if (failures == 0) begin
      $display("ordered_list_append_remove_core test passed");
    end else begin
      $display("ordered_list_append_remove_core test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/olar_pkg.sv
hdl/olar_store.sv
hdl/ordered_list_append_remove_core.sv
dv/ordered_list_append_remove_core_tb.sv
